// File: src/fpa_pkg.sv
`default_nettype none
package fpa_pkg;

	localparam int ACTIVE_W = 5;
	localparam int PIDX_W   = 4;
	localparam int FIELD_W  = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE     = 1'd1;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

	localparam logic ACT_LOAD     = 1'b0;
	localparam logic ACT_ALLOCATE = 1'b1;

	localparam logic POLICY_FIRST = 1'b0;
	localparam logic POLICY_BEST  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} scan_state_t;

	typedef struct packed {
		logic               done;
		logic               granted;
		logic [PIDX_W-1:0]  chosen_partition;
		logic [FIELD_W-1:0] remaining_size;
	} fpa_result_t;

endpackage
`default_nettype wire

// File: src/fit_partition_allocator.sv
`default_nettype none
// Partition allocator with first-fit and best-fit placement.
// Command channel: start with action, partition_index and size_value is taken
// at a clock edge where busy is low. A load beat writes one partition's free
// size at that edge and gives no result; busy stays low, so loads go every cycle.
// An allocate beat scans active partitions 0 .. min(active_partitions,
// NUM_PARTITIONS)-1, one RAM read per cycle. The result (granted,
// chosen_partition, remaining_size) is shown for one cycle with done high
// once the scan ends; the chosen partition is written back in that same cycle.
// After an allocate busy stays high, so no new beat is taken, through the reads
// on the single RAM read port, the last compare, a drain step and the done and
// write-back state; the next beat is taken once the scan is back in idle.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 fit_policy,
// 1 active_partitions) and cfg_data; cfg_ready is always high. Write while idle.
// Reset: fit_policy first fit, 16 active partitions, scan idle. Partition sizes
// are not cleared and must be loaded before they are scanned.
// done is a strobe; the receiver takes each result in its cycle and cannot stall.
module fit_partition_allocator #(
	parameter int NUM_PARTITIONS = 16,
	parameter int SIZE_BITS = 24
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic                                  action,
	input  wire logic [fpa_pkg::PIDX_W-1:0]            partition_index,
	input  wire logic [fpa_pkg::FIELD_W-1:0]           size_value,
	output logic                                       done,
	output logic                                       granted,
	output logic      [fpa_pkg::PIDX_W-1:0]            chosen_partition,
	output logic      [fpa_pkg::FIELD_W-1:0]           remaining_size,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [fpa_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [fpa_pkg::ACTIVE_W-1:0]          cfg_data
);

	import fpa_pkg::*;

	localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
	localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);
	localparam int CMP_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;

	logic                fit_policy_q;
	logic [ACTIVE_W-1:0] active_q;

	logic [CMP_W-1:0]     active_ext;
	logic [CMP_W-1:0]     pidx_ext;
	logic [CNT_W-1:0]     count;
	logic                 accept;
	logic                 load_we;
	logic                 go;
	logic [SIZE_BITS-1:0] size_in;

	logic                 scan_busy;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic [SIZE_BITS-1:0] rd_data;
	logic                 wb_en;
	logic [IDX_W-1:0]     wb_addr;
	logic [SIZE_BITS-1:0] wb_data;
	fpa_result_t          res;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [SIZE_BITS-1:0] ram_wdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q <= POLICY_FIRST;
			active_q     <= ACTIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIT_POLICY: fit_policy_q <= cfg_data[0];
				REG_ACTIVE:     active_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign active_ext = CMP_W'(active_q);
	assign pidx_ext   = CMP_W'(partition_index);
	assign count = (active_ext > CMP_W'(NUM_PARTITIONS)) ? CNT_W'(NUM_PARTITIONS)
		: CNT_W'(active_ext);

	assign size_in = SIZE_BITS'(size_value);
	assign accept  = start && !busy;
	assign load_we = accept && (action == ACT_LOAD) && (pidx_ext < CMP_W'(NUM_PARTITIONS));
	assign go      = accept && (action == ACT_ALLOCATE);

	assign ram_we    = load_we || wb_en;
	assign ram_waddr = wb_en ? wb_addr : pidx_ext[IDX_W-1:0];
	assign ram_wdata = wb_en ? wb_data : size_in;

	fpa_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(NUM_PARTITIONS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	fpa_scan #(
		.NUM_PARTITIONS(NUM_PARTITIONS),
		.SIZE_BITS(SIZE_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.policy  (fit_policy_q),
		.count   (count),
		.req_size(size_in),
		.rd_data (rd_data),
		.busy    (scan_busy),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_en   (wb_en),
		.wr_addr (wb_addr),
		.wr_data (wb_data),
		.res     (res)
	);

	assign busy             = scan_busy;
	assign done             = res.done;
	assign granted          = res.done && res.granted;
	assign chosen_partition = res.chosen_partition;
	assign remaining_size   = res.remaining_size;

endmodule
`default_nettype wire

// File: src/fpa_ram.sv
`default_nettype none
module fpa_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/fpa_scan.sv
`default_nettype none
module fpa_scan #(
	parameter int NUM_PARTITIONS = 16,
	parameter int SIZE_BITS = 24,
	parameter int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1,
	parameter int CNT_W = $clog2(NUM_PARTITIONS + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire logic                 policy,
	input  wire logic [CNT_W-1:0]     count,
	input  wire logic [SIZE_BITS-1:0] req_size,
	input  wire logic [SIZE_BITS-1:0] rd_data,
	output logic                      busy,
	output logic                      rd_en,
	output logic      [IDX_W-1:0]     rd_addr,
	output logic                      wr_en,
	output logic      [IDX_W-1:0]     wr_addr,
	output logic      [SIZE_BITS-1:0] wr_data,
	output fpa_pkg::fpa_result_t      res
);

	import fpa_pkg::*;

	scan_state_t state_q, state_d;

	logic [CNT_W-1:0]     rd_cnt_q;
	logic [CNT_W-1:0]     count_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 policy_q;
	logic                 valid_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] best_q;

	logic                 fits;
	logic [SIZE_BITS-1:0] left;
	logic                 take;

	function automatic logic req_size_ok(input logic [SIZE_BITS-1:0] avail,
		input logic [SIZE_BITS-1:0] req);
		return req <= avail;
	endfunction

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (go) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_cnt_q == count_q && !valid_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy  = (state_q != ST_IDLE);
		rd_en = (state_q == ST_SCAN) && (rd_cnt_q != count_q);
		wr_en = (state_q == ST_DONE) && found_q;
		res.done             = (state_q == ST_DONE);
		res.granted          = found_q;
		res.chosen_partition = found_q ? PIDX_W'(pick_q) : '0;
		res.remaining_size   = found_q ? FIELD_W'(best_q) : '0;
	end

	assign rd_addr = rd_cnt_q[IDX_W-1:0];
	assign wr_addr = pick_q;
	assign wr_data = best_q;

	assign fits = (req_size_ok(rd_data, size_q));
	assign left = rd_data - size_q;
	assign take = valid_s1 && fits &&
		(!found_q || (policy_q == POLICY_BEST && left < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= '0;
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= rd_en;
			if (go && state_q == ST_IDLE) begin
				rd_cnt_q <= '0;
				found_q  <= 1'b0;
			end else begin
				if (rd_en) begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && state_q == ST_IDLE) begin
			count_q  <= count;
			size_q   <= req_size;
			policy_q <= policy;
		end
		idx_s1 <= rd_addr;
		if (take) begin
			pick_q <= idx_s1;
			best_q <= left;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (rd_cnt_q <= count_q))
		else $error("scan read count past active count");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> !res.done)
		else $error("result strobe longer than one cycle");

	a_pick_active: assert property (@(posedge clk) disable iff (!arst_n)
		(res.done && res.granted) |-> (CNT_W'(pick_q) < count_q))
		else $error("granted partition outside active range");

	a_first_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && found_q && policy_q == POLICY_FIRST) |=> $stable(pick_q))
		else $error("first fit choice changed after a hit");
`endif

endmodule
`default_nettype wire
